// ===== src/euvf_pkg.sv =====
// Shared types, widths and constants for the encoder unwrap and velocity filter.
package euvf_pkg;

  // Field widths
  localparam int ANGLE_W   = 12;
  localparam int DT_W      = 24;
  localparam int TF_W      = 20;
  localparam int THR_W     = 12;
  localparam int VEL_W     = 32;
  localparam int TURN_BITS = 20;

  // Datapath widths
  localparam int DANGLE_W = ANGLE_W + 2;            // step*4096 + difference
  localparam int DEN_W    = DT_W + 1;               // filter time + elapsed
  localparam int OPB_W    = TF_W + 1;               // signed multiplier operand
  localparam int PROD_W   = VEL_W + OPB_W;          // product width
  localparam int NUM_W    = PROD_W + 1;             // sum of two products
  localparam int MAG_W    = NUM_W - 1;              // magnitude of numerator
  localparam int CNT_W    = $clog2(MAG_W);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TF_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THR    = 1'd1;

  localparam logic [TF_W-1:0]  FILTER_TIME_RESET = 20'd9000;
  localparam logic [THR_W-1:0] WRAP_THR_RESET    = 12'd3277;

  localparam logic signed [OPB_W-1:0] US_PER_S = 21'sd1000000;

  // One input beat
  typedef struct packed {
    logic [ANGLE_W-1:0] enc_angle;
    logic [DT_W-1:0]    elapsed_us;
    logic               read_failed;
  } sample_t;

  // One result beat
  typedef struct packed {
    logic [ANGLE_W-1:0]      single_turn_angle;
    logic signed [VEL_W-1:0] multi_turn_angle;
    logic signed [VEL_W-1:0] velocity;
    logic                    velocity_saturated;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch sample, update angle and turns
    logic mul_a;      // dangle * 1e6
    logic mul_b;      // filter time * previous velocity
    logic sum;        // add the two products
    logic div_init;   // load divider
    logic div_step;   // one quotient bit
    logic finish;     // clamp and store velocity
    logic clear_sat;  // zero denominator: clear flag, keep velocity
    logic load_out;   // capture result beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic read_failed;
    logic den_zero;
    logic div_last;
  } status_t;

endpackage

// ===== src/euvf_ctrl.sv =====
// Controller state machine: sequences unwrap, multiply, divide and result hand-off.
module euvf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  euvf_pkg::status_t status,
  output euvf_pkg::cmd_t    cmd
);
  import euvf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MUL_A    = 8'b0000_0010,
    S_MUL_B    = 8'b0000_0100,
    S_SUM      = 8'b0000_1000,
    S_DIV_INIT = 8'b0001_0000,
    S_DIV      = 8'b0010_0000,
    S_FINISH   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          state_next = status.read_failed ? S_DONE : S_MUL_A;
        end
      end
      S_MUL_A: begin
        if (status.den_zero) begin
          cmd.clear_sat = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.mul_a  = 1'b1;
          state_next = S_MUL_B;
        end
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result beat valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || result_ready))
    else $error("result loaded over a pending beat");

  // A stalled result holds the controller in its hand-off state
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_valid && !result_ready) |=> (state == S_DONE))
    else $error("left hand-off state while result stalled");

  // A failed read goes straight to hand-off
  assert property (@(posedge clk) disable iff (rst)
    (accept && status.read_failed) |=> (state == S_DONE))
    else $error("failed read entered the arithmetic");

  // Last divider step leads to finish
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_last) |=> (state == S_FINISH))
    else $error("divider did not finish after its last step");

endmodule

// ===== src/euvf_dp.sv =====
// Datapath: config registers, angle unwrap, shared multiplier, radix-2 divider, result register.
module euvf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [euvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [euvf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  euvf_pkg::sample_t                   sample,
  input  euvf_pkg::cmd_t                      cmd,
  output euvf_pkg::status_t                   status,
  output euvf_pkg::result_t                   result
);
  import euvf_pkg::*;

  localparam int MT_W  = TURN_BITS + ANGLE_W;
  localparam int EXT_W = (MT_W > VEL_W) ? MT_W : VEL_W;
  localparam logic signed [EXT_W-1:0] MT_HI = EXT_W'(32'sh7FFF_FFFF);
  localparam logic signed [EXT_W-1:0] MT_LO = EXT_W'(32'sh8000_0000);

  // Configuration
  logic [TF_W-1:0]  filter_time_us;
  logic [THR_W-1:0] wrap_threshold;

  // Held state
  logic [ANGLE_W-1:0]        last_angle;
  logic signed [TURN_BITS-1:0] turn_count;
  logic signed [VEL_W-1:0]   filtered_velocity;
  logic                      last_sat;

  // Working registers
  logic signed [DANGLE_W-1:0] dangle;
  logic [DEN_W-1:0]           den;
  logic signed [PROD_W-1:0]   prod;
  logic signed [NUM_W-1:0]    acc;
  logic [MAG_W-1:0]           quo;
  logic [DEN_W-1:0]           rem;
  logic                       num_neg;
  logic [CNT_W-1:0]           cnt;

  // Unwrap logic
  logic signed [ANGLE_W:0]    diff;
  logic [ANGLE_W-1:0]         diff_mag;
  logic                       wrap;
  logic signed [1:0]          step;
  logic signed [DANGLE_W-1:0] dangle_c;

  always_comb begin
    diff     = $signed({1'b0, sample.enc_angle}) - $signed({1'b0, last_angle});
    diff_mag = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
    wrap     = diff_mag > wrap_threshold;
    if (!wrap) begin
      step = 2'sd0;
    end else if (diff > 0) begin
      step = -2'sd1;
    end else begin
      step = 2'sd1;
    end
    dangle_c = DANGLE_W'(diff) + $signed({step, {ANGLE_W{1'b0}}});
  end

  // Shared multiplier, operands picked per step
  logic signed [VEL_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_c;

  assign op_a   = cmd.mul_b ? filtered_velocity : VEL_W'(dangle);
  assign op_b   = cmd.mul_b ? $signed({1'b0, filter_time_us}) : US_PER_S;
  assign prod_c = op_a * op_b;

  // Divider step
  logic [DEN_W:0] shifted;
  logic           ge;
  logic [DEN_W:0] diff_den;

  assign shifted  = {rem, quo[MAG_W-1]};
  assign diff_den = shifted - {1'b0, den};
  assign ge       = !diff_den[DEN_W];

  // Quotient sign and clamp
  logic [MAG_W-VEL_W:0]    q_hi;
  logic                    q_sat;
  logic signed [VEL_W-1:0] q_val;

  always_comb begin
    q_hi = quo[MAG_W-1:VEL_W-1];
    if (num_neg) begin
      q_sat = (q_hi != '0) && !((q_hi == (MAG_W-VEL_W+1)'(1)) && (quo[VEL_W-2:0] == '0));
      q_val = q_sat ? $signed(32'h8000_0000) : -$signed(quo[VEL_W-1:0]);
    end else begin
      q_sat = (q_hi != '0);
      q_val = q_sat ? $signed(32'h7FFF_FFFF) : $signed(quo[VEL_W-1:0]);
    end
  end

  // Multi-turn angle from held state
  logic signed [MT_W-1:0]  mt_full;
  logic signed [EXT_W-1:0] mt_ext;
  logic signed [VEL_W-1:0] mt_out;

  always_comb begin
    mt_full = $signed({turn_count, last_angle});
    mt_ext  = EXT_W'(mt_full);
    if (mt_ext > MT_HI) begin
      mt_out = $signed(32'h7FFF_FFFF);
    end else if (mt_ext < MT_LO) begin
      mt_out = $signed(32'h8000_0000);
    end else begin
      mt_out = VEL_W'(mt_ext);
    end
  end

  assign status.read_failed = sample.read_failed;
  assign status.den_zero    = (den == '0);
  assign status.div_last    = (cnt == CNT_W'(MAG_W - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_time_us <= FILTER_TIME_RESET;
      wrap_threshold <= WRAP_THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FILTER_TIME: filter_time_us <= cfg_wdata;
        CFG_WRAP_THR:    wrap_threshold <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Held state: angle, turns, velocity, flag
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle        <= '0;
      turn_count        <= '0;
      filtered_velocity <= '0;
      last_sat          <= 1'b0;
    end else begin
      if (cmd.accept && !sample.read_failed) begin
        last_angle <= sample.enc_angle;
        turn_count <= turn_count + TURN_BITS'(step);
      end
      if (cmd.clear_sat) begin
        last_sat <= 1'b0;
      end
      if (cmd.finish) begin
        filtered_velocity <= q_val;
        last_sat          <= q_sat;
      end
    end
  end

  // Arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dangle <= dangle_c;
      den    <= DEN_W'(filter_time_us) + DEN_W'(sample.elapsed_us);
    end
    if (cmd.mul_a || cmd.mul_b) begin
      prod <= prod_c;
    end
    if (cmd.mul_b) begin
      acc <= NUM_W'(prod);
    end
    if (cmd.sum) begin
      acc <= acc + NUM_W'(prod);
    end
    if (cmd.div_init) begin
      num_neg <= acc[NUM_W-1];
      quo     <= acc[NUM_W-1] ? MAG_W'(-acc) : acc[MAG_W-1:0];
      rem     <= '0;
      cnt     <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? diff_den[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[MAG_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.single_turn_angle  <= last_angle;
      result.multi_turn_angle   <= mt_out;
      result.velocity           <= filtered_velocity;
      result.velocity_saturated <= last_sat;
    end
  end

endmodule

// ===== src/encoder_unwrap_velocity_filter.sv =====
// Top level of the multi-turn encoder unwrap with low-pass velocity filter.
//
// Sample channel (sample_valid/sample_ready, payload sample): one beat per
// encoder reading with the 12-bit angle, microseconds since the last reading
// and a read-failed flag. Result channel (result_valid/result_ready, payload
// result): one beat per sample with single-turn angle, multi-turn angle,
// filtered velocity in counts per second and a saturation flag.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0: filter time constant in us, 1: wrap threshold in counts).
// Throughput: one sample at a time. A good reading passes from accept to
// result load through two multiply steps, sum, divider setup, 53 radix-2
// divider steps, finish and hand-off, and the radix-2 divider loop takes
// most of that time. A failed read goes from accept straight to hand-off, a
// zero denominator to hand-off from its first check, skipping the arithmetic.
// The result sits in an output register, so the next sample is accepted
// while the previous result still waits; a stalled receiver holds the block
// at hand-off once the following result is ready.
// Reset (rst, synchronous): angle, turns, velocity and flag go to zero, the
// time constant to 9000 us and the threshold to 3277 counts.
module encoder_unwrap_velocity_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  euvf_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output euvf_pkg::result_t               result,
  input  logic                            cfg_wr_en,
  input  logic [euvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [euvf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import euvf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  euvf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Arithmetic and state
  euvf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
